>>> src/kli_pkg.sv
// Shared constants for the keyframe linear interpolator: field widths, codes and defaults.
package kli_pkg;

    // Default table depth.
    localparam int MAX_KEYS_DEF = 64;

    // Field widths of one word on either channel.
    localparam int OP_W      = 2;
    localparam int FRAME_W   = 16;
    localparam int VALUE_W   = 32;
    localparam int IDX_W     = 6;
    localparam int CNT_OUT_W = 7;
    localparam int STATUS_W  = 2;

    // Packed stream widths, rounded up to whole bytes.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 48;

    // One table entry in memory: value above frame.
    localparam int ENTRY_W = VALUE_W + FRAME_W;

    // The quotient of an interpolation never needs more than 33 bits.
    localparam int DIV_STEPS = 33;
    localparam int STEP_W    = 6;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_QUERY  = 2'd0;
    localparam logic [OP_W-1:0] OP_SET    = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

endpackage

>>> src/kli_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module kli_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> src/keyframe_linear_interpolator_unit.sv
// Top level of the keyframe table with piecewise linear interpolation.
//
//  Channel  Direction  tdata (lowest bit up)                       tuser
//  s_       in         frame[15:0] value_in[47:16] entry_index[53:48]  op[1:0]
//  m_       out        value_out[31:0] entry_count[38:32] status[40:39]  -
//
// Work per accepted word: a query that lands on or outside the table needs at most a scan; one
// that interpolates needs a scan that reads one entry per cycle from the single table RAM,
// a multiply, 33 restoring divide steps and a final sum. A set scans, then moves one entry
// per cycle through the RAM's one write port, then inserts; a delete moves the entries
// above entry_index down one place.
// Reset is synchronous and empties the table at once; no clearing pass is needed.
// The input side is ready only when the sequencer is idle; a finished result waits in the
// output register, and the next word may be taken in the meantime.
module keyframe_linear_interpolator_unit #(
    parameter int MAX_KEYS = kli_pkg::MAX_KEYS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [kli_pkg::S_TDATA_W-1:0] s_tdata,  // frame, value_in, entry_index
    input  logic [kli_pkg::OP_W-1:0]      s_tuser,  // op
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [kli_pkg::M_TDATA_W-1:0] m_tdata   // value_out, entry_count, status
);

    localparam int PTR_W  = $clog2(MAX_KEYS + 1);
    localparam int ADDR_W = $clog2(MAX_KEYS);
    localparam int IDXC_W = ((PTR_W > kli_pkg::IDX_W) ? PTR_W : kli_pkg::IDX_W) + 1;
    localparam int FW     = kli_pkg::FRAME_W;
    localparam int VW     = kli_pkg::VALUE_W;
    localparam int EW     = kli_pkg::ENTRY_W;
    localparam int QW     = kli_pkg::DIV_STEPS;
    localparam int PW     = FW + VW;

    localparam logic [PTR_W-1:0] MAX_P = PTR_W'(MAX_KEYS);

    // Sequencer states.
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_MUL    = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_FIX    = 3'd4;
    localparam logic [2:0] S_SHIFT  = 3'd5;
    localparam logic [2:0] S_INSERT = 3'd6;
    localparam logic [2:0] S_DONE   = 3'd7;

    // Control registers.
    logic [2:0]       state_reg, state_next;
    logic [PTR_W-1:0] count_reg, count_next;
    logic             cmp_vld_reg, cmp_vld_next;
    logic             wr_pend_reg, wr_pend_next;
    logic             rd_more_reg, rd_more_next;
    logic             m_tvalid_reg, m_tvalid_next;

    // Payload and datapath registers.
    logic [kli_pkg::OP_W-1:0]     op_reg, op_next;
    logic [FW-1:0]                frame_reg, frame_next;
    logic [VW-1:0]                vin_reg, vin_next;
    logic [PTR_W-1:0]             ptr_reg, ptr_next;
    logic [PTR_W-1:0]             cmp_ptr_reg, cmp_ptr_next;
    logic [PTR_W-1:0]             pos_reg, pos_next;
    logic [PTR_W-1:0]             wr_ptr_reg, wr_ptr_next;
    logic [FW-1:0]                prev_frame_reg, prev_frame_next;
    logic [VW-1:0]                prev_value_reg, prev_value_next;
    logic [FW-1:0]                num_d_reg, num_d_next;
    logic [FW-1:0]                den_reg, den_next;
    logic [VW-1:0]                mag_reg, mag_next;
    logic                         neg_reg, neg_next;
    logic [VW-1:0]                base_reg, base_next;
    logic [FW-1:0]                rem_reg, rem_next;
    logic [QW-1:0]                quo_reg, quo_next;
    logic [kli_pkg::STEP_W-1:0]   step_reg, step_next;
    logic [VW-1:0]                res_value_reg, res_value_next;
    logic [kli_pkg::STATUS_W-1:0] res_status_reg, res_status_next;
    logic [VW-1:0]                out_value_reg, out_value_next;
    logic [kli_pkg::CNT_OUT_W-1:0] out_count_reg, out_count_next;
    logic [kli_pkg::STATUS_W-1:0] out_status_reg, out_status_next;

    // Table RAM ports.
    logic              ram_wr_en;
    logic [ADDR_W-1:0] ram_wr_addr;
    logic [EW-1:0]     ram_wr_data;
    logic [ADDR_W-1:0] ram_rd_addr;
    logic [EW-1:0]     ram_rd_data;
    logic [FW-1:0]     rd_frame;
    logic [VW-1:0]     rd_value;

    // Helpers for the scan, the divider and the final sum.
    logic              hit;
    logic              is_eq;
    logic              is_last;
    logic [VW:0]       diff;
    logic [PW-1:0]     prod;
    logic [FW:0]       trial;
    logic              ge;
    logic [QW:0]       q_signed;
    logic [VW+1:0]     sum;
    logic [IDXC_W-1:0] idx_wide;
    logic [IDXC_W-1:0] cnt_wide;
    logic              is_insert;

    kli_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_KEYS)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_frame = ram_rd_data[FW-1:0];
    assign rd_value = ram_rd_data[EW-1:FW];

    // Handshake outputs and packed result word.
    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(kli_pkg::M_TDATA_W - VW - kli_pkg::CNT_OUT_W - kli_pkg::STATUS_W){1'b0}},
                       out_status_reg, out_count_reg, out_value_reg};

    // Shared arithmetic: scan compare, difference, multiply, divide step, final sum.
    assign hit       = (rd_frame >= frame_reg);
    assign is_eq     = (rd_frame == frame_reg);
    assign is_last   = (cmp_ptr_reg == count_reg - PTR_W'(1));
    assign diff      = {rd_value[VW-1], rd_value} - {prev_value_reg[VW-1], prev_value_reg};
    assign prod      = PW'(num_d_reg) * PW'(mag_reg);
    assign trial     = {rem_reg, quo_reg[QW-1]} - {1'b0, den_reg};
    assign ge        = ({rem_reg, quo_reg[QW-1]} >= {1'b0, den_reg});
    assign q_signed  = neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};
    assign sum       = {{2{base_reg[VW-1]}}, base_reg} + q_signed;
    assign idx_wide  = IDXC_W'(s_tdata[FW+VW +: kli_pkg::IDX_W]);
    assign cnt_wide  = IDXC_W'(count_reg);
    assign is_insert = (op_reg == kli_pkg::OP_SET);

    // Sequencer.
    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        cmp_vld_next    = cmp_vld_reg;
        wr_pend_next    = wr_pend_reg;
        rd_more_next    = rd_more_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        op_next         = op_reg;
        frame_next      = frame_reg;
        vin_next        = vin_reg;
        ptr_next        = ptr_reg;
        cmp_ptr_next    = cmp_ptr_reg;
        pos_next        = pos_reg;
        wr_ptr_next     = wr_ptr_reg;
        prev_frame_next = prev_frame_reg;
        prev_value_next = prev_value_reg;
        num_d_next      = num_d_reg;
        den_next        = den_reg;
        mag_next        = mag_reg;
        neg_next        = neg_reg;
        base_next       = base_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        step_next       = step_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_value_next  = out_value_reg;
        out_count_next  = out_count_reg;
        out_status_next = out_status_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = pos_reg[ADDR_W-1:0];
        ram_wr_data     = {vin_reg, frame_reg};
        ram_rd_addr     = ptr_reg[ADDR_W-1:0];

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    op_next         = s_tuser;
                    frame_next      = s_tdata[FW-1:0];
                    vin_next        = s_tdata[FW +: VW];
                    res_value_next  = '0;
                    res_status_next = kli_pkg::STAT_OK;
                    ptr_next        = '0;
                    cmp_vld_next    = 1'b0;
                    wr_pend_next    = 1'b0;
                    case (s_tuser)
                        kli_pkg::OP_QUERY: begin
                            state_next = (count_reg == '0) ? S_DONE : S_SCAN;
                        end
                        kli_pkg::OP_SET: begin
                            pos_next   = '0;
                            state_next = (count_reg == '0) ? S_INSERT : S_SCAN;
                        end
                        kli_pkg::OP_DELETE: begin
                            if (idx_wide < cnt_wide) begin
                                count_next = count_reg - PTR_W'(1);
                                if ((idx_wide + IDXC_W'(1)) < cnt_wide) begin
                                    ptr_next     = PTR_W'(idx_wide + IDXC_W'(1));
                                    rd_more_next = 1'b1;
                                    state_next   = S_SHIFT;
                                end else begin
                                    state_next = S_DONE;
                                end
                            end else begin
                                res_status_next = kli_pkg::STAT_RANGE;
                                state_next      = S_DONE;
                            end
                        end
                        default: begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // One entry read per cycle; the compare sees each entry through the RAM's read register.
            S_SCAN: begin
                ptr_next     = ptr_reg + PTR_W'(1);
                cmp_ptr_next = ptr_reg;
                cmp_vld_next = 1'b1;
                if (cmp_vld_reg) begin
                    prev_frame_next = rd_frame;
                    prev_value_next = rd_value;
                    if (hit || is_last) begin
                        cmp_vld_next = 1'b0;
                        if (op_reg == kli_pkg::OP_QUERY) begin
                            if (!hit || is_eq || cmp_ptr_reg == '0) begin
                                res_value_next = rd_value;
                                state_next     = S_DONE;
                            end else begin
                                num_d_next = frame_reg - prev_frame_reg;
                                den_next   = rd_frame - prev_frame_reg;
                                neg_next   = diff[VW];
                                mag_next   = diff[VW] ? VW'(-diff) : diff[VW-1:0];
                                base_next  = prev_value_reg;
                                state_next = S_MUL;
                            end
                        end else if (hit && is_eq) begin
                            // Existing frame: overwrite its value in place.
                            ram_wr_en      = 1'b1;
                            ram_wr_addr    = cmp_ptr_reg[ADDR_W-1:0];
                            res_value_next = vin_reg;
                            state_next     = S_DONE;
                        end else if (count_reg == MAX_P) begin
                            res_status_next = kli_pkg::STAT_FULL;
                            state_next      = S_DONE;
                        end else if (!hit) begin
                            pos_next   = count_reg;
                            state_next = S_INSERT;
                        end else begin
                            pos_next     = cmp_ptr_reg;
                            ptr_next     = count_reg - PTR_W'(1);
                            rd_more_next = 1'b1;
                            state_next   = S_SHIFT;
                        end
                    end
                end
            end

            // Magnitude product, then load the divider with its top bits.
            S_MUL: begin
                rem_next   = FW'(prod[PW-1:QW]);
                quo_next   = prod[QW-1:0];
                step_next  = '0;
                state_next = S_DIV;
            end

            // Restoring division, one quotient bit per cycle.
            S_DIV: begin
                rem_next  = ge ? trial[FW-1:0] : {rem_reg[FW-2:0], quo_reg[QW-1]};
                quo_next  = {quo_reg[QW-2:0], ge};
                step_next = step_reg + kli_pkg::STEP_W'(1);
                if (step_reg == kli_pkg::STEP_W'(kli_pkg::DIV_STEPS - 1)) begin
                    state_next = S_FIX;
                end
            end

            S_FIX: begin
                res_value_next = sum[VW-1:0];
                state_next     = S_DONE;
            end

            // Move entries one place; each entry is written in the cycle after its read.
            S_SHIFT: begin
                if (wr_pend_reg) begin
                    ram_wr_en   = 1'b1;
                    ram_wr_addr = wr_ptr_reg[ADDR_W-1:0];
                    ram_wr_data = ram_rd_data;
                end
                if (rd_more_reg) begin
                    wr_pend_next = 1'b1;
                    if (is_insert) begin
                        wr_ptr_next = ptr_reg + PTR_W'(1);
                        ptr_next    = ptr_reg - PTR_W'(1);
                        if (ptr_reg == pos_reg) begin
                            rd_more_next = 1'b0;
                        end
                    end else begin
                        wr_ptr_next = ptr_reg - PTR_W'(1);
                        ptr_next    = ptr_reg + PTR_W'(1);
                        if (ptr_reg == count_reg) begin
                            rd_more_next = 1'b0;
                        end
                    end
                end else begin
                    wr_pend_next = 1'b0;
                    state_next   = is_insert ? S_INSERT : S_DONE;
                end
            end

            S_INSERT: begin
                ram_wr_en      = 1'b1;
                count_next     = count_reg + PTR_W'(1);
                res_value_next = vin_reg;
                state_next     = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    out_value_next  = res_value_reg;
                    out_count_next  = kli_pkg::CNT_OUT_W'(count_reg);
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            wr_pend_reg  <= 1'b0;
            rd_more_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            cmp_vld_reg  <= cmp_vld_next;
            wr_pend_reg  <= wr_pend_next;
            rd_more_reg  <= rd_more_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload and datapath.
    always_ff @(posedge aclk) begin
        op_reg         <= op_next;
        frame_reg      <= frame_next;
        vin_reg        <= vin_next;
        ptr_reg        <= ptr_next;
        cmp_ptr_reg    <= cmp_ptr_next;
        pos_reg        <= pos_next;
        wr_ptr_reg     <= wr_ptr_next;
        prev_frame_reg <= prev_frame_next;
        prev_value_reg <= prev_value_next;
        num_d_reg      <= num_d_next;
        den_reg        <= den_next;
        mag_reg        <= mag_next;
        neg_reg        <= neg_next;
        base_reg       <= base_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        step_reg       <= step_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_count_reg  <= out_count_next;
        out_status_reg <= out_status_next;
    end

`ifndef NO_ASSERTIONS
    // The table never holds more keys than it has room for.
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MAX_P)
        else $error("key count beyond table depth");

    // One word changes the key count by at most one.
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        !$stable(count_reg) |-> (count_reg == $past(count_reg) + PTR_W'(1) ||
                                 count_reg == $past(count_reg) - PTR_W'(1)))
        else $error("key count jumped");

    // A full report is only given with a full table.
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_status_reg == kli_pkg::STAT_FULL) |->
        (out_count_reg == kli_pkg::CNT_OUT_W'(MAX_KEYS)))
        else $error("full status with room left");

    // Interpolation operands: the span is non-zero and the offset lies inside it.
    a_mul_span: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MUL |-> (den_reg != '0 && num_d_reg < den_reg))
        else $error("interpolation span out of order");

    // The partial remainder stays below the divisor throughout the division.
    a_div_rem: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> rem_reg < den_reg)
        else $error("divider remainder overflow");
`endif

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the keyframe linear interpolator stream block.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_KEYS   = kli_pkg::MAX_KEYS_DEF;
    localparam int QUIET_MAX  = 4000;
    localparam int TAIL_WAIT  = 200;
    localparam int HOLD_LEN   = 400;

    // The block ignores the fourth operation code.
    localparam logic [kli_pkg::OP_W-1:0] OP_NOP = 2'd3;

    typedef struct {
        logic signed [kli_pkg::VALUE_W-1:0]   value;
        logic [kli_pkg::CNT_OUT_W-1:0]        count;
        logic [kli_pkg::STATUS_W-1:0]         status;
    } kf_result_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [kli_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [kli_pkg::OP_W-1:0]       s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [kli_pkg::M_TDATA_W-1:0]  m_tdata;

    // Predicted contents of the keyframe table.
    logic [kli_pkg::FRAME_W-1:0]        kf_frame [MAX_KEYS];
    logic signed [kli_pkg::VALUE_W-1:0] kf_value [MAX_KEYS];
    int                                 kf_count = 0;

    kf_result_t pending_results [$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_len       = 0;
    int quiet_cycles   = 0;
    int fail_count     = 0;
    int words_checked  = 0;

    // Tallies of what the traffic reached, for the closing summary.
    int n_query = 0, n_interp = 0, n_set = 0, n_full = 0;
    int n_delete = 0, n_range = 0, n_nop = 0;

    keyframe_linear_interpolator_unit #(
        .MAX_KEYS (MAX_KEYS)
    ) u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 aclk = ~aclk;

    // Applies one accepted word to the predicted table and returns its result.
    function automatic kf_result_t apply_keyframe_word(
        input logic [kli_pkg::OP_W-1:0] op,
        input logic [kli_pkg::FRAME_W-1:0] frame,
        input logic signed [kli_pkg::VALUE_W-1:0] vin,
        input logic [kli_pkg::IDX_W-1:0] idx);
        kf_result_t res;
        int         pos;
        bit         hit;
        longint     num;
        longint     quo;
        res.value  = '0;
        res.status = kli_pkg::STAT_OK;
        hit        = 1'b0;
        case (op)
            kli_pkg::OP_QUERY: begin
                n_query++;
                if (kf_count == 0) begin
                    res.value = '0;
                end else if (frame <= kf_frame[0]) begin
                    res.value = kf_value[0];
                end else if (frame >= kf_frame[kf_count-1]) begin
                    res.value = kf_value[kf_count-1];
                end else begin
                    for (pos = 0; pos + 1 < kf_count && !hit; pos++) begin
                        if (frame >= kf_frame[pos] && frame <= kf_frame[pos+1]) begin
                            num = (longint'(frame) - longint'(kf_frame[pos]))
                                * (longint'(kf_value[pos+1]) - longint'(kf_value[pos]));
                            quo = num / (longint'(kf_frame[pos+1]) - longint'(kf_frame[pos]));
                            res.value = kli_pkg::VALUE_W'(longint'(kf_value[pos]) + quo);
                            hit = 1'b1;
                            n_interp++;
                        end
                    end
                end
            end
            kli_pkg::OP_SET: begin
                for (pos = 0; pos < kf_count && !hit; pos++) begin
                    if (kf_frame[pos] == frame) begin
                        kf_value[pos] = vin;
                        hit = 1'b1;
                    end
                end
                if (hit) begin
                    res.value = vin;
                    n_set++;
                end else if (kf_count >= MAX_KEYS) begin
                    res.status = kli_pkg::STAT_FULL;
                    n_full++;
                end else begin
                    pos = 0;
                    while (pos < kf_count && kf_frame[pos] < frame) pos++;
                    for (int i = kf_count; i > pos; i--) begin
                        kf_frame[i] = kf_frame[i-1];
                        kf_value[i] = kf_value[i-1];
                    end
                    kf_frame[pos] = frame;
                    kf_value[pos] = vin;
                    kf_count++;
                    res.value = vin;
                    n_set++;
                end
            end
            kli_pkg::OP_DELETE: begin
                if (int'(idx) < kf_count) begin
                    for (int i = idx; i + 1 < kf_count; i++) begin
                        kf_frame[i] = kf_frame[i+1];
                        kf_value[i] = kf_value[i+1];
                    end
                    kf_count--;
                    n_delete++;
                end else begin
                    res.status = kli_pkg::STAT_RANGE;
                    n_range++;
                end
            end
            default: begin
                n_nop++;
            end
        endcase
        res.count = kli_pkg::CNT_OUT_W'(kf_count);
        return res;
    endfunction

    function automatic bit is_key_frame(input logic [kli_pkg::FRAME_W-1:0] frame);
        for (int i = 0; i < kf_count; i++) begin
            if (kf_frame[i] == frame) return 1'b1;
        end
        return 1'b0;
    endfunction

    // Frames lean towards existing keys and their neighbours so that hits and
    // one-frame segments come up often.
    function automatic logic [kli_pkg::FRAME_W-1:0] pick_frame();
        int sel;
        sel = $urandom_range(9);
        if (kf_count > 0 && sel < 3) return kf_frame[$urandom_range(kf_count - 1)];
        if (kf_count > 0 && sel == 3)
            return kf_frame[$urandom_range(kf_count - 1)]
                   + kli_pkg::FRAME_W'($urandom_range(4)) - 16'd2;
        if (sel == 4) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
        return kli_pkg::FRAME_W'($urandom_range(65535));
    endfunction

    function automatic logic signed [kli_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(3))
            0: return $signed(kli_pkg::VALUE_W'($urandom_range(2000))) - 32'sd1000;
            1: begin
                case ($urandom_range(3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7FFF_FFFF;
                    2: return 32'sh0000_0000;
                    default: return -32'sd1;
                endcase
            end
            default: return $signed($urandom);
        endcase
    endfunction

    // Offers one word, waits for it to be taken and records its expected result.
    task automatic send_word(input logic [kli_pkg::OP_W-1:0] op,
                             input logic [kli_pkg::FRAME_W-1:0] frame,
                             input logic signed [kli_pkg::VALUE_W-1:0] vin,
                             input logic [kli_pkg::IDX_W-1:0] idx);
        kf_result_t res;
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, idx, vin, frame};
        do @(posedge aclk); while (!s_tready);
        res = apply_keyframe_word(op, frame, vin, idx);
        pending_results = {pending_results, res};
    endtask

    // Stops offering and waits until every expected word has come back.
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic send_random_word(input int set_pct, input int del_pct);
        int                          r;
        logic [kli_pkg::IDX_W-1:0]   idx;
        r = $urandom_range(99);
        if (r < 2) begin
            send_word(OP_NOP, kli_pkg::FRAME_W'($urandom), pick_value(),
                      kli_pkg::IDX_W'($urandom));
        end else if (r < 2 + set_pct) begin
            send_word(kli_pkg::OP_SET, pick_frame(), pick_value(), kli_pkg::IDX_W'($urandom));
        end else if (r < 2 + set_pct + del_pct) begin
            if (kf_count > 0 && $urandom_range(99) < 85)
                idx = kli_pkg::IDX_W'($urandom_range(kf_count - 1));
            else
                idx = kli_pkg::IDX_W'($urandom_range(63));
            send_word(kli_pkg::OP_DELETE, kli_pkg::FRAME_W'($urandom), pick_value(), idx);
        end else begin
            send_word(kli_pkg::OP_QUERY, pick_frame(), pick_value(), kli_pkg::IDX_W'($urandom));
        end
    endtask

    task automatic set_idling(input int sender_pct, input int receiver_pct);
        send_idle_pct  = sender_pct;
        recv_stall_pct = receiver_pct;
    endtask

    // Empty table, lookups around a lone key, steep and negative slopes, rounding of
    // negative quotients, overwrites, and deletes in and out of range.
    task automatic test_directed_cases();
        send_word(kli_pkg::OP_QUERY,  16'd0,     32'sd0,          6'd0);
        send_word(kli_pkg::OP_QUERY,  16'hFFFF,  32'sd0,          6'd63);
        send_word(kli_pkg::OP_DELETE, 16'd0,     32'sd0,          6'd0);
        send_word(OP_NOP,             16'hFFFF,  32'sh7FFF_FFFF,  6'd63);
        send_word(kli_pkg::OP_SET,    16'd1000,  32'sh7FFF_FFFF,  6'd0);
        send_word(kli_pkg::OP_QUERY,  16'd0,     32'sd0,          6'd0);
        send_word(kli_pkg::OP_QUERY,  16'd1000,  32'sd0,          6'd0);
        send_word(kli_pkg::OP_QUERY,  16'hFFFF,  32'sd0,          6'd0);
        send_word(kli_pkg::OP_SET,    16'd0,     32'sh8000_0000,  6'd0);
        send_word(kli_pkg::OP_SET,    16'hFFFF,  32'sh7FFF_FFFF,  6'd0);
        send_word(kli_pkg::OP_QUERY,  16'd500,   32'sd0,          6'd0);
        send_word(kli_pkg::OP_QUERY,  16'd1,     32'sd0,          6'd0);
        send_word(kli_pkg::OP_SET,    16'd40000, 32'sh8000_0000,  6'd0);
        send_word(kli_pkg::OP_QUERY,  16'd20000, 32'sd0,          6'd0);
        send_word(kli_pkg::OP_SET,    16'd1000,  -32'sd5,         6'd0);
        send_word(kli_pkg::OP_SET,    16'd2000,  32'sd0,          6'd0);
        send_word(kli_pkg::OP_SET,    16'd2003,  -32'sd7,         6'd0);
        send_word(kli_pkg::OP_QUERY,  16'd2001,  32'sd0,          6'd0);
        send_word(kli_pkg::OP_QUERY,  16'd2002,  32'sd0,          6'd0);
        send_word(kli_pkg::OP_DELETE, 16'd0,     32'sd0,          6'd63);
        send_word(kli_pkg::OP_DELETE, 16'd0,     32'sd0,          6'd0);
        send_word(OP_NOP,             16'd0,     32'sd0,          6'd0);
    endtask

    // Fills the table, tries new frames against it, overwrites an old one, then queries and deletes.
    task automatic test_full_table();
        int                          guard;
        logic [kli_pkg::FRAME_W-1:0] fr;
        guard = 0;
        while (kf_count < MAX_KEYS && guard < 400) begin
            send_word(kli_pkg::OP_SET, kli_pkg::FRAME_W'($urandom), pick_value(),
                      kli_pkg::IDX_W'($urandom));
            guard++;
        end
        for (int i = 0; i < 3; i++) begin
            fr = kli_pkg::FRAME_W'($urandom);
            while (is_key_frame(fr)) fr = kli_pkg::FRAME_W'($urandom);
            send_word(kli_pkg::OP_SET, fr, pick_value(), 6'd0);
        end
        send_word(kli_pkg::OP_SET, kf_frame[$urandom_range(kf_count - 1)], pick_value(), 6'd0);
        for (int i = 0; i < 4; i++) send_word(kli_pkg::OP_QUERY, pick_frame(), 32'sd0, 6'd0);
        send_word(kli_pkg::OP_DELETE, 16'd0, 32'sd0, 6'd63);
        send_word(kli_pkg::OP_DELETE, 16'd0, 32'sd0, 6'd0);
    endtask

    task automatic test_random_traffic(input int words, input int set_pct, input int del_pct);
        for (int i = 0; i < words; i++) send_random_word(set_pct, del_pct);
    endtask

    // The receiver holds off for a long stretch while words keep coming.
    task automatic test_output_backpressure();
        set_idling(0, 0);
        hold_len = HOLD_LEN;
        test_random_traffic(40, 30, 20);
        wait_drain();
    endtask

    // The sender pauses until every result is back, then carries on.
    task automatic test_drain_pause();
        set_idling(0, 0);
        test_random_traffic(15, 30, 20);
        wait_drain();
        test_random_traffic(15, 30, 20);
    endtask

    // Receiver: random stalls, with an occasional long hold counted here.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_tready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Compares each returned word with the oldest expectation.
    always @(posedge aclk) begin
        kf_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result word: %h", m_tdata);
                fail_count++;
            end else begin
                want = pending_results.pop_front();
                words_checked++;
                if (m_tdata[31:0] !== want.value) begin
                    $error("value_out mismatch: expected %0d, got %0d",
                           want.value, $signed(m_tdata[31:0]));
                    fail_count++;
                end
                if (m_tdata[38:32] !== want.count) begin
                    $error("entry_count mismatch: expected %0d, got %0d",
                           want.count, m_tdata[38:32]);
                    fail_count++;
                end
                if (m_tdata[40:39] !== want.status) begin
                    $error("status mismatch: expected %0d, got %0d",
                           want.status, m_tdata[40:39]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither side moves a word.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_MAX) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Test sequence.
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_cases();
        test_full_table();
        set_idling(0, 0);
        test_random_traffic(300, 30, 15);
        set_idling(75, 0);
        test_random_traffic(250, 25, 25);
        set_idling(0, 75);
        test_random_traffic(300, 35, 20);
        set_idling(13, 13);
        test_random_traffic(300, 30, 20);
        test_output_backpressure();
        test_drain_pause();

        wait_drain();
        repeat (TAIL_WAIT) @(posedge aclk);

        $display("Checked %0d result words: %0d queries (%0d interpolated), %0d sets,",
                 words_checked, n_query, n_interp, n_set);
        $display("%0d inserts refused on a full table, %0d deletes, %0d bad indexes, %0d no-ops.",
                 n_full, n_delete, n_range, n_nop);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

>>> keyframe_linear_interpolator_unit.f
src/kli_pkg.sv
src/kli_ram.sv
src/keyframe_linear_interpolator_unit.sv
tb/sv/testbench.sv
